>>> rtl/core/i2p_pkg.sv
// infix to postfix converter: shared types, character codes and rank decoder
// no dependencies; used by the stack cell, the top level and the testbench
`default_nettype none

package i2p_pkg;

    // default operator stack depth
    localparam int STACK_DEPTH_DEF = 32;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    // operator ranks
    localparam logic [2:0] RANK_OPEN  = 3'd0;
    localparam logic [2:0] RANK_OR    = 3'd1;
    localparam logic [2:0] RANK_AND   = 3'd2;
    localparam logic [2:0] RANK_CMP   = 3'd3;
    localparam logic [2:0] RANK_ADD   = 3'd4;
    localparam logic [2:0] RANK_MUL   = 3'd5;
    localparam logic [2:0] RANK_UNARY = 3'd6;

    // one stack entry
    typedef struct packed {
        logic [7:0] sym;
        logic [2:0] rank;
    } t_entry;

    // shift command broadcast to every stack cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } t_cell_op;

    // control states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_FLUSH,
        ST_CLOSE,
        ST_OPER,
        ST_PUSH2,
        ST_FIN
    } t_state;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_A) && (c <= CH_Z);
    endfunction

    // binary rank after a letter or a close paren, unary rank otherwise
    function automatic logic [2:0] op_rank(input logic [7:0] c, input logic [7:0] prev);
        logic [2:0] r;
        r = RANK_UNARY;
        if (prev == CH_CLOSE || is_letter(prev)) begin
            unique case (c) inside
                CH_BAR:            r = RANK_OR;
                CH_AMP:            r = RANK_AND;
                CH_LT, CH_GT:      r = RANK_CMP;
                CH_MINUS, CH_PLUS: r = RANK_ADD;
                CH_SLASH, CH_STAR: r = RANK_MUL;
                CH_BANG:           r = RANK_UNARY;
                default:           r = RANK_UNARY;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/i2p_if.sv
// valid/ready channel interfaces for the infix to postfix converter
// input channel carries one character per beat, output one postfix character
`default_nettype none

interface i2p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface i2p_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;
    logic       error;

    modport source (output valid, output out_char, output last, output error, input ready);
    modport sink   (input valid, input out_char, input last, input error, output ready);
endinterface

`default_nettype wire

>>> rtl/core/infix_to_postfix_converter.sv
// infix to postfix converter top level: control sequencer and cell-chain stack
// depends on i2p_pkg, i2p_in_if, i2p_out_if and i2p_cell
`default_nettype none

// Usage
// i_in takes one ASCII character per beat; o_out gives postfix characters,
// each with last (final character caused by that input) and error (stack
// underflow or overflow in that step). A zero character flushes the stack
// and ends with a newline beat marked last.
// Operator entries live in a row of cells; a push or pop shifts every cell by
// one place, so stacked entries leave one at a time.
// One character is worked on at a time: i_in.ready is high only when the
// previous character is done. A letter goes from the emit state to the output
// register. An operator pops entries of equal or higher rank, then pushes
// itself (twice for a doubled and/or); a close paren pops up to its open
// paren; a flush pops every entry, then gives the newline. An unmatched
// close or an open paren on a full stack ends in an error step.
// The output register lets a character be accepted while the last result
// still waits; a stalled receiver holds the sequencer at its next emitting
// step, nothing is dropped.
// Reset clears state, stack and paren counts, previous character, skip flag
// and output valid; the stack cells are not cleared and need no clearing pass.

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    i2p_in_if.sink      i_in,
    i2p_out_if.source   o_out
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    i2p_pkg::t_state   r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_paren, n_paren;
    logic [7:0]        r_prev, n_prev;
    logic              r_skip, n_skip;
    logic [7:0]        r_sym, n_sym;
    logic [2:0]        r_rank, n_rank;
    logic              r_dbl, n_dbl;
    logic              r_err, n_err;
    logic              r_emitted, n_emitted;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_char, n_out_char;
    logic              r_out_last, n_out_last;
    logic              r_out_err, n_out_err;

    i2p_pkg::t_cell_op w_cell_op;
    i2p_pkg::t_entry   w_new;
    i2p_pkg::t_entry   w_cells [STACK_DEPTH];
    i2p_pkg::t_entry   w_top, w_next;

    logic              w_accept, w_slot, w_empty, w_one, w_full, w_almost;
    logic [2:0]        w_in_rank;
    logic              w_in_dbl, w_pop1, w_pop2, w_op_err, w_pop_ok;
    logic              w_emit;
    logic [7:0]        w_emit_char;
    logic              w_emit_last, w_emit_err;

    // stack as a chain of cells, top at index 0
    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        i2p_pkg::t_entry w_upper, w_lower;
        if (gi == 0) begin : g_first
            assign w_upper = w_new;
        end else begin : g_mid_up
            assign w_upper = w_cells[gi-1];
        end
        if (gi == STACK_DEPTH - 1) begin : g_bottom
            assign w_lower = w_cells[gi];
        end else begin : g_mid_lo
            assign w_lower = w_cells[gi+1];
        end
        i2p_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op),
            .i_upper (w_upper),
            .i_lower (w_lower),
            .o_entry (w_cells[gi])
        );
    end

    assign w_top  = w_cells[0];
    assign w_next = w_cells[1];

    // handshake and stack status
    assign i_in.ready = i_rst_n && (r_state == i2p_pkg::ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_slot     = !r_out_valid || o_out.ready;
    assign w_empty    = (r_count == '0);
    assign w_one      = (r_count == CW'(1));
    assign w_full     = (r_count == CW'(STACK_DEPTH));
    assign w_almost   = (r_count == CW'(STACK_DEPTH - 1));

    // overflow of an incoming operator, known before its pops
    assign w_in_rank = i2p_pkg::op_rank(i_in.symbol, r_prev);
    assign w_in_dbl  = (i_in.symbol == i2p_pkg::CH_AMP) || (i_in.symbol == i2p_pkg::CH_BAR);
    assign w_pop1    = !w_empty && (w_top.rank >= w_in_rank);
    assign w_pop2    = w_pop1 && !w_one && (w_next.rank >= w_in_rank);
    assign w_op_err  = (w_full && (w_in_dbl ? !w_pop2 : !w_pop1))
                     || (w_almost && w_in_dbl && !w_pop1);

    assign w_pop_ok  = !w_empty && (w_top.rank >= r_rank);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2p_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.symbol == i2p_pkg::CH_NUL) begin
                        n_state = i2p_pkg::ST_FLUSH;
                    end else if (r_skip) begin
                        n_state = i2p_pkg::ST_IDLE;
                    end else if (i2p_pkg::is_letter(i_in.symbol)) begin
                        n_state = i2p_pkg::ST_EMIT;
                    end else if (i_in.symbol == i2p_pkg::CH_OPEN) begin
                        n_state = w_full ? i2p_pkg::ST_FIN : i2p_pkg::ST_IDLE;
                    end else if (i_in.symbol == i2p_pkg::CH_CLOSE) begin
                        n_state = i2p_pkg::ST_CLOSE;
                    end else begin
                        n_state = i2p_pkg::ST_OPER;
                    end
                end
            end
            i2p_pkg::ST_EMIT: begin
                if (w_slot) n_state = i2p_pkg::ST_IDLE;
            end
            i2p_pkg::ST_FLUSH: begin
                if (w_slot && w_empty) n_state = i2p_pkg::ST_IDLE;
            end
            i2p_pkg::ST_CLOSE: begin
                if (w_empty) begin
                    n_state = i2p_pkg::ST_FIN;
                end else if (w_top.sym == i2p_pkg::CH_OPEN) begin
                    n_state = i2p_pkg::ST_IDLE;
                end
            end
            i2p_pkg::ST_OPER: begin
                if (!w_pop_ok) n_state = r_dbl ? i2p_pkg::ST_PUSH2 : i2p_pkg::ST_FIN;
            end
            i2p_pkg::ST_PUSH2: begin
                n_state = i2p_pkg::ST_FIN;
            end
            i2p_pkg::ST_FIN: begin
                if (!(r_err && !r_emitted) || w_slot) n_state = i2p_pkg::ST_IDLE;
            end
            default: n_state = i2p_pkg::ST_IDLE;
        endcase
    end

    // stack control, emitted beats and step registers
    always_comb begin
        n_count     = r_count;
        n_paren     = r_paren;
        n_prev      = r_prev;
        n_skip      = r_skip;
        n_sym       = r_sym;
        n_rank      = r_rank;
        n_dbl       = r_dbl;
        n_err       = r_err;
        n_emitted   = r_emitted;
        w_cell_op   = i2p_pkg::CELL_HOLD;
        w_new       = '{sym: r_sym, rank: r_rank};
        w_emit      = 1'b0;
        w_emit_char = r_sym;
        w_emit_last = 1'b0;
        w_emit_err  = 1'b0;
        unique case (r_state)
            i2p_pkg::ST_IDLE: begin
                w_new = '{sym: i2p_pkg::CH_OPEN, rank: i2p_pkg::RANK_OPEN};
                if (w_accept) begin
                    n_sym     = i_in.symbol;
                    n_err     = 1'b0;
                    n_emitted = 1'b0;
                    if (i_in.symbol == i2p_pkg::CH_NUL) begin
                        // the flush empties the stack, so no open paren survives it
                        n_prev  = i2p_pkg::CH_NUL;
                        n_skip  = 1'b0;
                        n_paren = '0;
                    end else if (r_skip) begin
                        n_prev = i_in.symbol;
                        n_skip = 1'b0;
                    end else begin
                        n_prev = i_in.symbol;
                        if (i2p_pkg::is_letter(i_in.symbol)) begin
                            n_err = 1'b0;
                        end else if (i_in.symbol == i2p_pkg::CH_OPEN) begin
                            if (w_full) begin
                                n_err = 1'b1;
                            end else begin
                                w_cell_op = i2p_pkg::CELL_PUSH;
                                n_count   = r_count + CW'(1);
                                n_paren   = r_paren + CW'(1);
                            end
                        end else if (i_in.symbol == i2p_pkg::CH_CLOSE) begin
                            n_err = (r_paren == '0);
                        end else begin
                            n_rank = w_in_rank;
                            n_dbl  = w_in_dbl;
                            n_err  = w_op_err;
                            n_skip = w_in_dbl;
                        end
                    end
                end
            end
            i2p_pkg::ST_EMIT: begin
                if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_char = r_sym;
                    w_emit_last = 1'b1;
                end
            end
            i2p_pkg::ST_FLUSH: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    if (!w_empty) begin
                        w_emit_char = w_top.sym;
                        w_cell_op   = i2p_pkg::CELL_POP;
                        n_count     = r_count - CW'(1);
                    end else begin
                        w_emit_char = i2p_pkg::CH_LF;
                        w_emit_last = 1'b1;
                    end
                end
            end
            i2p_pkg::ST_CLOSE: begin
                if (!w_empty) begin
                    if (w_top.sym == i2p_pkg::CH_OPEN) begin
                        w_cell_op = i2p_pkg::CELL_POP;
                        n_count   = r_count - CW'(1);
                        n_paren   = r_paren - CW'(1);
                    end else if (w_slot) begin
                        w_emit      = 1'b1;
                        w_emit_char = w_top.sym;
                        w_emit_last = w_one || (w_next.sym == i2p_pkg::CH_OPEN);
                        w_emit_err  = r_err;
                        w_cell_op   = i2p_pkg::CELL_POP;
                        n_count     = r_count - CW'(1);
                        n_emitted   = 1'b1;
                    end
                end
            end
            i2p_pkg::ST_OPER: begin
                if (w_pop_ok) begin
                    if (w_slot) begin
                        w_emit      = 1'b1;
                        w_emit_char = w_top.sym;
                        w_emit_last = w_one || (w_next.rank < r_rank);
                        w_emit_err  = r_err;
                        w_cell_op   = i2p_pkg::CELL_POP;
                        n_count     = r_count - CW'(1);
                        n_emitted   = 1'b1;
                    end
                end else if (!w_full) begin
                    w_cell_op = i2p_pkg::CELL_PUSH;
                    n_count   = r_count + CW'(1);
                end
            end
            i2p_pkg::ST_PUSH2: begin
                if (!w_full) begin
                    w_cell_op = i2p_pkg::CELL_PUSH;
                    n_count   = r_count + CW'(1);
                end
            end
            i2p_pkg::ST_FIN: begin
                // error step with nothing emitted gives a single zero beat
                if (r_err && !r_emitted && w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_char = i2p_pkg::CH_NUL;
                    w_emit_last = 1'b1;
                    w_emit_err  = 1'b1;
                end
            end
            default: begin
                w_cell_op = i2p_pkg::CELL_HOLD;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = w_emit || (r_out_valid && !o_out.ready);
        n_out_char  = w_emit ? w_emit_char : r_out_char;
        n_out_last  = w_emit ? w_emit_last : r_out_last;
        n_out_err   = w_emit ? w_emit_err  : r_out_err;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2p_pkg::ST_IDLE;
            r_count     <= '0;
            r_paren     <= '0;
            r_prev      <= i2p_pkg::CH_NUL;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_paren     <= n_paren;
            r_prev      <= n_prev;
            r_skip      <= n_skip;
            r_out_valid <= n_out_valid;
        end
    end

    // step and beat payload
    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_rank     <= n_rank;
        r_dbl      <= n_dbl;
        r_err      <= n_err;
        r_emitted  <= n_emitted;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.last     = r_out_last;
    assign o_out.error    = r_out_err;

    // stack count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // open parens on the stack are a subset of all entries
    a_paren_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_paren <= r_count)
        else $error("open paren count exceeds stack count");

    // a pending skip always follows a doubled operator
    a_skip_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_prev == i2p_pkg::CH_AMP || r_prev == i2p_pkg::CH_BAR))
        else $error("skip pending without a doubled operator");

    // a zero character starts a flush and returns to expression start
    a_flush_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.symbol == i2p_pkg::CH_NUL)
        |=> (r_state == i2p_pkg::ST_FLUSH && !r_skip && r_prev == i2p_pkg::CH_NUL))
        else $error("flush did not start on zero character");

endmodule

`default_nettype wire

>>> rtl/core/i2p_cell.sv
// one operator stack cell: holds the entry at a fixed depth from the top
// depends on i2p_pkg for the entry type and the shift command
`default_nettype none

module i2p_cell (
    input  wire logic              i_clk,
    input  wire i2p_pkg::t_cell_op i_op,
    input  wire i2p_pkg::t_entry   i_upper,
    input  wire i2p_pkg::t_entry   i_lower,
    output i2p_pkg::t_entry        o_entry
);

    i2p_pkg::t_entry r_entry;
    i2p_pkg::t_entry n_entry;

    // push takes the entry above, pop takes the entry below
    always_comb begin
        case (i_op)
            i2p_pkg::CELL_PUSH: n_entry = i_upper;
            i2p_pkg::CELL_POP:  n_entry = i_lower;
            default:            n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> test/tb_infix_to_postfix_converter.sv
// testbench for infix_to_postfix_converter: drives characters, predicts postfix beats
// depends on i2p_pkg, i2p_in_if, i2p_out_if and the converter from the rtl; no files or arguments

module tb_infix_to_postfix_converter;

    localparam int DEPTH      = i2p_pkg::STACK_DEPTH_DEF;
    localparam int PLAN_ITEMS = 450;
    localparam int HOLD_LEN   = 300;

    // one expected output beat
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } t_postfix_beat;

    // operator stack model plus the queue of postfix beats still owed
    class postfix_scoreboard;
        logic [7:0]    op_sym[DEPTH];
        logic [2:0]    op_rank[DEPTH];
        int            used;
        logic [7:0]    prev_sym;
        bit            skip_next;
        t_postfix_beat owed[$];
        int            errors;

        function new();
            used      = 0;
            prev_sym  = i2p_pkg::CH_NUL;
            skip_next = 1'b0;
            errors    = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // binary rank only after a letter or a close paren
        function logic [2:0] rank_for(logic [7:0] sym);
            if (prev_sym != i2p_pkg::CH_CLOSE
                && !(prev_sym >= i2p_pkg::CH_A && prev_sym <= i2p_pkg::CH_Z))
                return i2p_pkg::RANK_UNARY;
            case (sym)
                i2p_pkg::CH_BAR:                     return i2p_pkg::RANK_OR;
                i2p_pkg::CH_AMP:                     return i2p_pkg::RANK_AND;
                i2p_pkg::CH_LT, i2p_pkg::CH_GT:      return i2p_pkg::RANK_CMP;
                i2p_pkg::CH_MINUS, i2p_pkg::CH_PLUS: return i2p_pkg::RANK_ADD;
                i2p_pkg::CH_SLASH, i2p_pkg::CH_STAR: return i2p_pkg::RANK_MUL;
                default:                             return i2p_pkg::RANK_UNARY;
            endcase
        endfunction

        // a push onto a full stack is dropped
        function bit push_op(logic [7:0] sym, logic [2:0] rank);
            if (used >= DEPTH)
                return 1'b0;
            op_sym[used]  = sym;
            op_rank[used] = rank;
            used++;
            return 1'b1;
        endfunction

        function void note_symbol(logic [7:0] sym);
            logic [7:0]    outs[$];
            bit            err;
            bit            found;
            logic [2:0]    r;
            t_postfix_beat b;
            err = 1'b0;
            if (sym == i2p_pkg::CH_NUL) begin
                // flush: pop everything, then newline
                while (used > 0) begin
                    used--;
                    outs.push_back(op_sym[used]);
                end
                outs.push_back(i2p_pkg::CH_LF);
                prev_sym  = i2p_pkg::CH_NUL;
                skip_next = 1'b0;
            end else if (skip_next) begin
                // second half of a doubled and/or is swallowed
                skip_next = 1'b0;
                prev_sym  = sym;
            end else begin
                if (sym >= i2p_pkg::CH_A && sym <= i2p_pkg::CH_Z) begin
                    outs.push_back(sym);
                end else if (sym == i2p_pkg::CH_OPEN) begin
                    if (!push_op(i2p_pkg::CH_OPEN, i2p_pkg::RANK_OPEN))
                        err = 1'b1;
                end else if (sym == i2p_pkg::CH_CLOSE) begin
                    // pop up to the matching open paren
                    found = 1'b0;
                    while (used > 0 && !found) begin
                        used--;
                        if (op_sym[used] == i2p_pkg::CH_OPEN)
                            found = 1'b1;
                        else
                            outs.push_back(op_sym[used]);
                    end
                    if (!found)
                        err = 1'b1;
                end else begin
                    r = rank_for(sym);
                    while (used > 0 && op_rank[used-1] >= r) begin
                        used--;
                        outs.push_back(op_sym[used]);
                    end
                    if (!push_op(sym, r))
                        err = 1'b1;
                    if (sym == i2p_pkg::CH_AMP || sym == i2p_pkg::CH_BAR) begin
                        if (!push_op(sym, r))
                            err = 1'b1;
                        skip_next = 1'b1;
                    end
                end
                prev_sym = sym;
            end
            // an error step always says so with at least one beat
            if (err && outs.size() == 0)
                outs.push_back(i2p_pkg::CH_NUL);
            foreach (outs[k]) begin
                b.ch   = outs[k];
                b.last = (k == outs.size() - 1);
                b.err  = err;
                owed.push_back(b);
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_beat(t_postfix_beat got);
            t_postfix_beat want;
            if (owed.size() == 0) begin
                report($sformatf("unexpected beat char %02h last %b error %b",
                                 got.ch, got.last, got.err));
                return;
            end
            want = owed.pop_front();
            if (got !== want)
                report($sformatf({"expected char %02h last %b error %b, ",
                                  "got char %02h last %b error %b"},
                                 want.ch, want.last, want.err,
                                 got.ch, got.last, got.err));
        endfunction

        function void check_drained();
            if (owed.size() != 0)
                report($sformatf("%0d beats never arrived", owed.size()));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    i2p_in_if  in_ch ();
    i2p_out_if out_ch ();

    infix_to_postfix_converter #(
        .STACK_DEPTH (DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    postfix_scoreboard book = new();
    logic [7:0]        plan[$];

    // 12 unit clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // output monitor
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            book.check_beat({out_ch.out_char, out_ch.last, out_ch.error});
    end

    // ---------------------------------------------------------------- stimulus plan

    function automatic logic [7:0] pick_operator();
        logic [7:0] ops[9];
        ops = '{i2p_pkg::CH_BAR, i2p_pkg::CH_AMP, i2p_pkg::CH_LT, i2p_pkg::CH_GT,
                i2p_pkg::CH_MINUS, i2p_pkg::CH_PLUS, i2p_pkg::CH_SLASH,
                i2p_pkg::CH_STAR, i2p_pkg::CH_BANG};
        return ops[$urandom_range(0, 8)];
    endfunction

    function automatic logic [7:0] pick_letter();
        return 8'(i2p_pkg::CH_A + $urandom_range(0, 25));
    endfunction

    task automatic plan_text(input string s);
        foreach (s[i])
            plan.push_back(s[i]);
    endtask

    // doubled and/or mirrors the two-character form, so the skip eats the twin
    task automatic plan_operator(input logic [7:0] op);
        plan.push_back(op);
        if (op == i2p_pkg::CH_AMP || op == i2p_pkg::CH_BAR)
            plan.push_back(op);
    endtask

    // well-formed expression with random content; broken ones lose their tail
    task automatic plan_expression(input bit broken);
        int depth;
        int len;
        bit want_operand;
        int r;
        depth        = 0;
        len          = $urandom_range(1, 8);
        want_operand = 1'b1;
        while (len > 0 || want_operand) begin
            if (want_operand) begin
                r = $urandom_range(0, 9);
                if (r < 2 && depth < 6) begin
                    plan.push_back(i2p_pkg::CH_OPEN);
                    depth++;
                end else if (r == 2) begin
                    plan_operator(pick_operator());
                end else begin
                    plan.push_back(pick_letter());
                    want_operand = 1'b0;
                    len--;
                end
            end else if (depth > 0 && $urandom_range(0, 3) == 0) begin
                plan.push_back(i2p_pkg::CH_CLOSE);
                depth--;
            end else begin
                plan_operator(pick_operator());
                want_operand = 1'b1;
            end
        end
        if (broken && $urandom_range(0, 1) == 1) begin
            plan.push_back(i2p_pkg::CH_CLOSE);
            plan.push_back(i2p_pkg::CH_CLOSE);
        end else begin
            while (depth > 0) begin
                plan.push_back(i2p_pkg::CH_CLOSE);
                depth--;
            end
        end
        // a broken expression may also run on into the next one
        if (!(broken && $urandom_range(0, 2) == 0))
            plan.push_back(i2p_pkg::CH_NUL);
    endtask

    task automatic build_plan();
        int r;
        // directed: unary start, doubled or with its twin, zero while skip pending
        plan_text("!A||B&");
        plan.push_back(i2p_pkg::CH_NUL);
        // unmatched close on an empty stack
        plan_text(")");
        // compare, add and multiply ranks inside parens, unknown code after a close, unary after op
        plan_text("(A<B-C/D*E)");
        plan.push_back(8'hFF);
        plan_text("Z>+");
        plan.push_back(i2p_pkg::CH_NUL);

        while (plan.size() < PLAN_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r < 12) begin
                plan_expression(1'b0);
            end else if (r < 14) begin
                plan_expression(1'b1);
            end else if (r < 17) begin
                // raw noise bytes
                repeat ($urandom_range(1, 6))
                    plan.push_back(8'($urandom_range(1, 255)));
            end else if (r == 17) begin
                // open paren run from just under to past the stack depth
                repeat ($urandom_range(DEPTH - 2, DEPTH + 4))
                    plan.push_back(i2p_pkg::CH_OPEN);
                plan.push_back(pick_letter());
                if ($urandom_range(0, 1) == 1)
                    plan.push_back(i2p_pkg::CH_CLOSE);
                plan.push_back(i2p_pkg::CH_NUL);
            end else if (r == 18) begin
                // doubled push landing on a nearly full or full stack
                repeat ($urandom_range(DEPTH - 3, DEPTH + 1))
                    plan.push_back(i2p_pkg::CH_OPEN);
                plan.push_back(pick_letter());
                plan_operator($urandom_range(0, 1) ? i2p_pkg::CH_AMP : i2p_pkg::CH_BAR);
                plan.push_back(pick_letter());
                plan.push_back(i2p_pkg::CH_NUL);
            end else begin
                // an empty paren pair, a filled one and an unmatched close
                plan_text("()(A)");
                plan.push_back(i2p_pkg::CH_CLOSE);
                plan.push_back(i2p_pkg::CH_NUL);
            end
        end
    endtask

    // ---------------------------------------------------------------- drivers

    task automatic send_symbol(input logic [7:0] sym);
        in_ch.valid  <= 1'b1;
        in_ch.symbol <= sym;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        book.note_symbol(sym);
    endtask

    // receiver: phases of free flow, random stalls and sparse accepts, one long hold
    initial begin : sink_pattern
        int  cyc;
        int  span;
        int  mode;
        int  wait_cnt;
        bit  held;
        out_ch.ready <= 1'b0;
        cyc      = 0;
        wait_cnt = 0;
        held     = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (!held && cyc > 400) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_LEN)
                    @(posedge clk);
                cyc += HOLD_LEN;
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 80);
            repeat (span) begin
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if (wait_cnt == 0) begin
                            out_ch.ready <= 1'b1;
                            wait_cnt = $urandom_range(1, 7);
                        end else begin
                            out_ch.ready <= 1'b0;
                            wait_cnt--;
                        end
                    end
                endcase
                @(posedge clk);
                cyc++;
            end
        end
    end

    // run limit
    initial begin : watchdog
        #(12 * 500000);
        $display("simulation failed");
        $finish;
    end

    // reset, sender, drain and verdict
    initial begin : run_control
        int idx;
        int burst;
        int gap;
        int waited;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.symbol <= 8'h00;
        build_plan();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bursts of beats with random gaps
        idx = 0;
        while (idx < plan.size()) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && idx < plan.size()) begin
                send_symbol(plan[idx]);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        in_ch.valid <= 1'b0;

        // wait for the owed beats, then wait on so that stray extra beats are caught
        waited = 0;
        while (book.pending() != 0 && waited < 50000) begin
            @(posedge clk);
            waited++;
        end
        repeat (DEPTH + 16)
            @(posedge clk);
        book.check_drained();

        if (book.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
